// ===== design/vhmm_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vhmm_pkg
// Shared types, request codes and helpers of the Poisson HMM Viterbi decoder.
// ---------------------------------------------------------------------------
package vhmm_pkg;

  // Default sizes.
  localparam int MAX_STATES_D = 8;
  localparam int MAX_LEN_D    = 64;
  localparam int MAX_COUNT_D  = 256;
  localparam int FRAC_BITS_D  = 16;

  // Width of a log factorial entry (covers the largest count range).
  localparam int LF_W = 40;

  // One third with 44 fraction bits, the atanh argument that gives ln(2).
  localparam longint unsigned Q44_THIRD = (64'd1 << 44) / 64'd3;

  // Request codes.
  localparam logic [1:0] REQ_TRANS  = 2'd0;
  localparam logic [1:0] REQ_PARAM  = 2'd1;
  localparam logic [1:0] REQ_OBS    = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Register addresses (word index).
  localparam logic REG_NUM_STATES = 1'b0;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         from_state;
    logic [2:0]         to_state;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic [30:0]        value_c;
    logic [7:0]         obs_count;
    logic               obs_last;
  } in_t;

  typedef struct packed {
    logic [2:0] path_state;
    logic [5:0] time_step;
    logic       path_end;
    logic       overflow_error;
  } out_t;

  // Saturating signed 32-bit addition.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  // Restoring long division for table building; den stays below 2^62.
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q, r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((num >> b) & 64'd1);
      if (r >= den) begin
        r = r - den;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // (a*b) >> 44 from 22-bit halves.
  function automatic longint unsigned mulq(input longint unsigned a,
                                           input longint unsigned b);
    longint unsigned ah, al, bh, bl;
    ah = a >> 22;
    al = a & 64'h3F_FFFF;
    bh = b >> 22;
    bl = b & 64'h3F_FFFF;
    return ah * bh + ((ah * bl + al * bh) >> 22) + ((al * bl) >> 44);
  endfunction

  // atanh(z) with 44 fraction bits, for 0 <= z <= 1/3.
  function automatic longint unsigned atanh_q(input longint unsigned z);
    longint unsigned zz, term, sum;
    int d;
    zz   = mulq(z, z);
    term = z;
    sum  = 0;
    d    = 1;
    while (d < 200 && term != 0) begin
      sum  = sum + udiv(term, 64'(d));
      term = mulq(term, zz);
      d    = d + 2;
    end
    return sum;
  endfunction

  // ln(k) with 44 fraction bits for k >= 1; evaluated at elaboration only.
  function automatic longint unsigned ln_q44(input int k);
    longint unsigned ln2, z, lnk;
    int e, base;
    ln2 = 2 * atanh_q(Q44_THIRD);
    e   = 0;
    while (e < 30 && (k >> (e + 1)) != 0) begin
      e = e + 1;
    end
    base = 1 << e;
    lnk  = 64'(e) * ln2;
    if (k != base) begin
      z   = udiv(64'(k - base) << 44, 64'(k + base));
      lnk = lnk + 2 * atanh_q(z);
    end
    return lnk;
  endfunction

endpackage
`default_nettype wire

// ===== design/vhmm_emission.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vhmm_emission
// Two-stage Poisson log emission: count*log_rate - rate - ln(count!),
// saturated to signed 32 bits; each stage ends in a register.
// ---------------------------------------------------------------------------
module vhmm_emission #(
  parameter int MAX_COUNT = vhmm_pkg::MAX_COUNT_D,
  parameter int FRAC_BITS = vhmm_pkg::FRAC_BITS_D
) (
  input  wire logic               clk,
  input  wire logic [7:0]         count,
  input  wire logic signed [31:0] log_rate,
  input  wire logic [30:0]        rate,
  output logic signed [31:0]      em
);

  localparam int CW = $clog2(MAX_COUNT);
  localparam int EW = vhmm_pkg::LF_W + 12;

  typedef logic [MAX_COUNT-1:0][vhmm_pkg::LF_W-1:0] rom_t;

  // Log factorial table as a running sum of ln(k), rounded to FRAC_BITS.
  function automatic rom_t build_rom();
    rom_t            rom;
    longint unsigned acc, half;
    acc  = 0;
    half = 64'd1 << (43 - FRAC_BITS);
    for (int n = 0; n < MAX_COUNT; n++) begin
      if (n >= 2) begin
        acc = acc + vhmm_pkg::ln_q44(n);
      end
      rom[n] = vhmm_pkg::LF_W'((acc + half) >> (44 - FRAC_BITS));
    end
    return rom;
  endfunction

  localparam rom_t LF_ROM = build_rom();

  logic [CW-1:0]             ci;
  logic signed [40:0]        prod_r;
  logic [vhmm_pkg::LF_W:0]   sub_r;
  logic signed [EW-1:0]      diff;
  logic signed [31:0]        em_r;

  // Counts beyond the table use its last entry.
  assign ci = (32'(count) < MAX_COUNT) ? CW'(count) : CW'(MAX_COUNT - 1);

  // Stage one: product and the subtracted terms.
  always_ff @(posedge clk) begin
    prod_r <= $signed({1'b0, count}) * log_rate;
    sub_r  <= (vhmm_pkg::LF_W + 1)'(rate) + (vhmm_pkg::LF_W + 1)'(LF_ROM[ci]);
  end

  assign diff = EW'(prod_r) - $signed(EW'(sub_r));

  // Stage two: saturate.
  always_ff @(posedge clk) begin
    if (diff > EW'(32'sh7FFF_FFFF)) begin
      em_r <= 32'sh7FFF_FFFF;
    end else if (diff < -(EW'(64'sh8000_0000))) begin
      em_r <= 32'sh8000_0000;
    end else begin
      em_r <= diff[31:0];
    end
  end

  assign em = em_r;

endmodule
`default_nettype wire

// ===== design/poisson_hmm_viterbi_decoder_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// poisson_hmm_viterbi_decoder_top
// Log-domain Viterbi decoder for an HMM with Poisson emissions.
// ---------------------------------------------------------------------------
// Usage: a request is taken when start is high and busy is low. Load requests
// write the transition memory or a state's parameters in that cycle and do
// not raise busy. An observation runs a sequencer over the N states in use:
// per state S_EM1 and S_EM2 for the emission unit, then for later time steps
// one read per source state from the transition and score memories (S_SCAN)
// into the shared add-compare-select and one write (S_WR), or for the first
// step S_INIT_WR only. Once the backpointer store is full, observations just
// set the overflow flag. On an observation marked last, the final scores are
// scanned (S_ARG) and the backpointer memory is traced back, alternating
// S_TB_OUT and S_TB_WAIT, from the last time step to time step zero; path_end
// marks the final one. out_strobe marks each entry for exactly one cycle and
// the receiver cannot hold it off. busy stays high until the last entry is out.
// Reset returns the sequencer to idle, the time counter and overflow flag to
// zero and num_states to 2; the tables hold no value until loaded.
// The configuration port is a small APB slave with num_states at address 0.
// ---------------------------------------------------------------------------
module poisson_hmm_viterbi_decoder_top #(
  parameter int MAX_STATES = vhmm_pkg::MAX_STATES_D,
  parameter int MAX_LEN    = vhmm_pkg::MAX_LEN_D,
  parameter int MAX_COUNT  = vhmm_pkg::MAX_COUNT_D,
  parameter int FRAC_BITS  = vhmm_pkg::FRAC_BITS_D
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire vhmm_pkg::in_t in_data,
  output logic               out_strobe,
  output vhmm_pkg::out_t     out_data,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int SW = $clog2(MAX_STATES);
  localparam int LW = $clog2(MAX_LEN);
  localparam int TW = $clog2(MAX_LEN + 1);
  localparam logic REG_SEL = vhmm_pkg::REG_NUM_STATES;

  typedef enum logic [3:0] {
    S_IDLE, S_EM1, S_EM2, S_INIT_WR, S_SCAN, S_WR, S_ARG, S_TB_OUT, S_TB_WAIT
  } state_t;

  state_t state_r;

  logic [3:0]         num_states_r;
  logic [SW:0]        n_use;
  logic [SW:0]        n_r;
  logic [SW-1:0]      last_idx;
  vhmm_pkg::in_t      req_r;
  logic               accept;

  // Tables and memories.
  logic signed [31:0] trans_mem [1 << (2 * SW)];
  logic signed [31:0] score_mem [2 << SW];
  logic [SW-1:0]      bp_mem    [MAX_LEN << SW];
  logic signed [31:0] log_init  [MAX_STATES];
  logic signed [31:0] log_rate  [MAX_STATES];
  logic [30:0]        rate_val  [MAX_STATES];

  logic signed [31:0] tr_q;
  logic signed [31:0] sc_q;
  logic [SW-1:0]      bp_q;

  // Score bank and written marks per state.
  logic [MAX_STATES-1:0] loc_r;
  logic [MAX_STATES-1:0] seen_r;

  logic [SW-1:0]      i_r;
  logic [SW-1:0]      k_r;
  logic               iss_done_r;
  logic               rd_vld_r;
  logic [SW-1:0]      rd_k_r;
  logic               rd_seen_r;
  logic signed [31:0] best_r;
  logic [SW-1:0]      arg_r;
  logic [TW-1:0]      t_r;
  logic               ovf_r;
  logic [TW-1:0]      j_r;
  logic [SW-1:0]      s_r;
  logic               out_strobe_r;
  vhmm_pkg::out_t     out_data_r;

  logic signed [31:0] em;
  logic signed [31:0] sc_val;
  logic signed [31:0] cand;
  logic               take;
  logic [SW+2:0]      fs_ext;
  logic [SW+2:0]      ts_ext;
  logic               sc_we;
  logic [SW:0]        sc_waddr;
  logic signed [31:0] sc_wdata;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEL) ? {28'd0, num_states_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_states_r <= 4'd2;
    end else if (psel && penable && pwrite && paddr[2] == REG_SEL) begin
      num_states_r <= pwdata[3:0];
    end
  end

  // States in use, clamped to the supported range.
  always_comb begin
    if (num_states_r < 4'd2) begin
      n_use = (SW + 1)'(2);
    end else if (32'(num_states_r) > MAX_STATES) begin
      n_use = (SW + 1)'(MAX_STATES);
    end else begin
      n_use = (SW + 1)'(num_states_r);
    end
  end

  assign last_idx = SW'(n_r - (SW + 1)'(1));

  // Load requests go straight into the tables.
  assign fs_ext = (SW + 3)'(in_data.from_state);
  assign ts_ext = (SW + 3)'(in_data.to_state);

  always_ff @(posedge clk) begin
    if (accept && in_data.req_type == vhmm_pkg::REQ_TRANS &&
        32'(in_data.from_state) < MAX_STATES && 32'(in_data.to_state) < MAX_STATES) begin
      trans_mem[{fs_ext[SW-1:0], ts_ext[SW-1:0]}] <= in_data.value_a;
    end
    if (accept && in_data.req_type == vhmm_pkg::REQ_PARAM &&
        32'(in_data.from_state) < MAX_STATES) begin
      log_init[fs_ext[SW-1:0]] <= in_data.value_a;
      log_rate[fs_ext[SW-1:0]] <= in_data.value_b;
      rate_val[fs_ext[SW-1:0]] <= in_data.value_c;
    end
    tr_q <= trans_mem[{k_r, i_r}];
  end

  // Emission unit for the current state.
  vhmm_emission #(
    .MAX_COUNT (MAX_COUNT),
    .FRAC_BITS (FRAC_BITS)
  ) u_emission (
    .clk      (clk),
    .count    (req_r.obs_count),
    .log_rate (log_rate[i_r]),
    .rate     (rate_val[i_r]),
    .em       (em)
  );

  // Score memory: new scores go to the bank opposite the live one.
  always_comb begin
    sc_we    = (state_r == S_WR) || (state_r == S_INIT_WR);
    sc_waddr = {~loc_r[i_r], i_r};
    if (state_r == S_WR) begin
      sc_wdata = vhmm_pkg::sat_add(best_r, em);
    end else begin
      sc_wdata = vhmm_pkg::sat_add(log_init[i_r], em);
    end
  end

  always_ff @(posedge clk) begin
    if (sc_we) begin
      score_mem[sc_waddr] <= sc_wdata;
    end
    sc_q <= score_mem[{loc_r[k_r], k_r}];
  end

  // Backpointer memory.
  always_ff @(posedge clk) begin
    if (state_r == S_WR) begin
      bp_mem[{t_r[LW-1:0], i_r}] <= arg_r;
    end
    bp_q <= bp_mem[{j_r[LW-1:0], s_r}];
  end

  // Candidate of the returning read: a path score, or a final score.
  assign sc_val = rd_seen_r ? sc_q : 32'sd0;
  assign cand   = (state_r == S_ARG) ? sc_val : vhmm_pkg::sat_add(sc_val, tr_q);
  assign take   = (rd_k_r == '0) || (cand > best_r);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      t_r          <= '0;
      ovf_r        <= 1'b0;
      seen_r       <= '0;
      loc_r        <= '0;
      out_strobe_r <= 1'b0;
      rd_vld_r     <= 1'b0;
      iss_done_r   <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept && in_data.req_type == vhmm_pkg::REQ_OBS) begin
            req_r      <= in_data;
            n_r        <= n_use;
            i_r        <= '0;
            k_r        <= '0;
            iss_done_r <= 1'b0;
            rd_vld_r   <= 1'b0;
            if (32'(t_r) >= MAX_LEN) begin
              ovf_r <= 1'b1;
              if (in_data.obs_last) begin
                state_r <= S_ARG;
              end
            end else begin
              state_r <= S_EM1;
            end
          end
        end
        S_EM1: begin
          state_r <= S_EM2;
        end
        S_EM2: begin
          k_r        <= '0;
          iss_done_r <= 1'b0;
          rd_vld_r   <= 1'b0;
          state_r    <= (t_r == '0) ? S_INIT_WR : S_SCAN;
        end
        S_SCAN, S_ARG: begin
          // Issue one read per cycle, fold in the data of the previous one.
          rd_vld_r  <= !iss_done_r;
          rd_k_r    <= k_r;
          rd_seen_r <= seen_r[k_r];
          if (!iss_done_r) begin
            if (k_r == last_idx) begin
              iss_done_r <= 1'b1;
            end else begin
              k_r <= k_r + SW'(1);
            end
          end
          if (rd_vld_r) begin
            if (take) begin
              best_r <= cand;
              arg_r  <= rd_k_r;
            end
            if (rd_k_r == last_idx) begin
              if (state_r == S_SCAN) begin
                state_r <= S_WR;
              end else begin
                s_r     <= take ? rd_k_r : arg_r;
                j_r     <= t_r - TW'(1);
                state_r <= S_TB_OUT;
              end
            end
          end
        end
        S_WR, S_INIT_WR: begin
          if (i_r == last_idx) begin
            // Observation done: new scores become the live ones.
            for (int q = 0; q < MAX_STATES; q++) begin
              if (q < 32'(n_r)) begin
                loc_r[q]  <= ~loc_r[q];
                seen_r[q] <= 1'b1;
              end
            end
            t_r        <= t_r + TW'(1);
            k_r        <= '0;
            iss_done_r <= 1'b0;
            rd_vld_r   <= 1'b0;
            state_r    <= req_r.obs_last ? S_ARG : S_IDLE;
          end else begin
            i_r     <= i_r + SW'(1);
            state_r <= S_EM1;
          end
        end
        S_TB_OUT: begin
          out_strobe_r              <= 1'b1;
          out_data_r.path_state     <= 3'(s_r);
          out_data_r.time_step      <= 6'(j_r);
          out_data_r.path_end       <= (j_r == '0);
          out_data_r.overflow_error <= ovf_r;
          if (j_r == '0) begin
            t_r     <= '0;
            ovf_r   <= 1'b0;
            seen_r  <= '0;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_TB_WAIT;
          end
        end
        S_TB_WAIT: begin
          s_r     <= bp_q;
          j_r     <= j_r - TW'(1);
          state_r <= S_TB_OUT;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Poisson HMM Viterbi decoder testbench
// Loads the log tables, runs directed and random observation sequences over
// several state counts, and compares each emitted path entry with a
// cycle-free software Viterbi predictor kept inside the testbench.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int NST      = 8;
  localparam int SEQ_MAX  = 64;
  localparam int WD_LIMIT = 6000;
  localparam int IN_W     = $bits(vhmm_pkg::in_t);

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  vhmm_pkg::in_t    in_data;
  logic             out_strobe;
  vhmm_pkg::out_t   out_data;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  poisson_hmm_viterbi_decoder_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // Predictor state: tables, scores, backpointers and sequence position.
  longint          trans_tab[NST*NST];
  longint          init_tab[NST];
  longint          lrate_tab[NST];
  longint          rate_tab[NST];
  longint          score_prev[NST];
  longint          score_cur[NST];
  int              bptr[SEQ_MAX*NST];
  int              seq_pos;
  bit              seq_ovf;
  logic [3:0]      nstates_reg;
  longint          lnfact[256];

  vhmm_pkg::out_t  path_q[$];
  int              err_cnt;
  int              item_cnt;
  int              stall_cnt;
  bit              calm;

  // Clock.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Fixed-point helpers for the log factorial table (44 fraction bits).
  function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
    longint unsigned ah, al, bh, bl;
    ah = a >> 22;
    al = a & 64'h3F_FFFF;
    bh = b >> 22;
    bl = b & 64'h3F_FFFF;
    return ah * bh + ((ah * bl + al * bh) >> 22) + ((al * bl) >> 44);
  endfunction

  function automatic longint unsigned fx_atanh(longint unsigned z);
    longint unsigned zz, term, acc;
    longint unsigned d;
    zz   = fx_mul(z, z);
    term = z;
    acc  = 0;
    d    = 1;
    while (d < 200 && term != 0) begin
      acc  = acc + term / d;
      term = fx_mul(term, zz);
      d    = d + 2;
    end
    return acc;
  endfunction

  task automatic build_lnfact();
    longint unsigned ln2, acc, half, z, lnk;
    int e;
    ln2  = 2 * fx_atanh((64'd1 << 44) / 64'd3);
    acc  = 0;
    half = 64'd1 << (44 - 16 - 1);
    for (int n = 0; n < 256; n++) begin
      if (n >= 2) begin
        e = 0;
        while (e < 31 && (n >> (e + 1)) != 0) e++;
        lnk = longint'(e) * ln2;
        if (n != (1 << e)) begin
          z   = (longint'(n - (1 << e)) << 44) / longint'(n + (1 << e));
          lnk = lnk + 2 * fx_atanh(z);
        end
        acc = acc + lnk;
      end
      lnfact[n] = longint'((acc + half) >> 28);
    end
  endtask

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint emit_score(int st, int cnt);
    return clip32(longint'(cnt) * lrate_tab[st] - rate_tab[st] - lnfact[cnt]);
  endfunction

  // Viterbi predictor: updates the tables or scores and queues path entries.
  task automatic predict_path(vhmm_pkg::in_t it);
    int             n, arg, s;
    longint         best, cand;
    vhmm_pkg::out_t o;
    case (it.req_type)
      vhmm_pkg::REQ_TRANS:
        trans_tab[it.from_state*NST + it.to_state] = longint'(it.value_a);
      vhmm_pkg::REQ_PARAM: begin
        init_tab[it.from_state]  = longint'(it.value_a);
        lrate_tab[it.from_state] = longint'(it.value_b);
        rate_tab[it.from_state]  = longint'({1'b0, it.value_c});
      end
      vhmm_pkg::REQ_OBS: begin
        n = (nstates_reg < 2) ? 2 : (nstates_reg > NST) ? NST : int'(nstates_reg);
        if (seq_pos >= SEQ_MAX) begin
          seq_ovf = 1'b1;
        end else begin
          for (int i = 0; i < n; i++) begin
            if (seq_pos == 0) begin
              score_cur[i] = clip32(init_tab[i] + emit_score(i, it.obs_count));
            end else begin
              best = clip32(score_prev[0] + trans_tab[i]);
              arg  = 0;
              for (int k = 1; k < n; k++) begin
                cand = clip32(score_prev[k] + trans_tab[k*NST + i]);
                if (cand > best) begin
                  best = cand;
                  arg  = k;
                end
              end
              bptr[seq_pos*NST + i] = arg;
              score_cur[i] = clip32(best + emit_score(i, it.obs_count));
            end
          end
          for (int i = 0; i < n; i++) score_prev[i] = score_cur[i];
          seq_pos++;
        end
        if (it.obs_last) begin
          s = 0;
          for (int i = 1; i < n; i++) if (score_prev[i] > score_prev[s]) s = i;
          for (int j = seq_pos - 1; j >= 0; j--) begin
            o.path_state     = 3'(s);
            o.time_step      = 6'(j);
            o.path_end       = (j == 0);
            o.overflow_error = seq_ovf;
            path_q.push_back(o);
            if (j > 0) s = bptr[j*NST + s];
          end
          seq_pos = 0;
          seq_ovf = 1'b0;
          for (int i = 0; i < NST; i++) begin
            score_prev[i] = 0;
            score_cur[i]  = 0;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // Result checker: every strobed path entry against the oldest expectation.
  always @(posedge clk) begin
    vhmm_pkg::out_t want;
    if (rst_n && out_strobe) begin
      if (path_q.size() == 0) begin
        report("unexpected path entry, time_step", out_data.time_step, -1);
      end else begin
        want = path_q.pop_front();
        if (out_data.path_state !== want.path_state)
          report("path_state", out_data.path_state, want.path_state);
        if (out_data.time_step !== want.time_step)
          report("time_step", out_data.time_step, want.time_step);
        if (out_data.path_end !== want.path_end)
          report("path_end", out_data.path_end, want.path_end);
        if (out_data.overflow_error !== want.overflow_error)
          report("overflow_error", out_data.overflow_error, want.overflow_error);
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (psel && penable)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= WD_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Send one request; start stays high afterward until the caller idles.
  task automatic send_item(vhmm_pkg::in_t it);
    while (!calm && $urandom_range(99) < 38) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    in_data = it;
    start   = 1'b1;
    do @(posedge clk); while (busy);
    predict_path(it);
    if (it.req_type != vhmm_pkg::REQ_UNUSED) item_cnt++;
  endtask

  // Stop sending and wait until the block is idle with no path outstanding.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    do @(posedge clk); while (busy || path_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_nstates(logic [3:0] v);
    drain();
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    paddr   = {2'(vhmm_pkg::REG_NUM_STATES), 1'b0} << 1;
    pwdata  = {$urandom} & ~32'hF | 32'(v);
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    nstates_reg = v;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Request builders; unused fields carry random bits.
  function automatic vhmm_pkg::in_t rand_bits();
    vhmm_pkg::in_t it;
    it = IN_W'({$urandom, $urandom, $urandom, $urandom});
    return it;
  endfunction

  function automatic vhmm_pkg::in_t mk_trans(int f, int t, logic [31:0] a);
    vhmm_pkg::in_t it;
    it = rand_bits();
    it.req_type   = vhmm_pkg::REQ_TRANS;
    it.from_state = 3'(f);
    it.to_state   = 3'(t);
    it.value_a    = a;
    return it;
  endfunction

  function automatic vhmm_pkg::in_t mk_param(int s, logic [31:0] a, logic [31:0] b,
                                             logic [30:0] c);
    vhmm_pkg::in_t it;
    it = rand_bits();
    it.req_type   = vhmm_pkg::REQ_PARAM;
    it.from_state = 3'(s);
    it.value_a    = a;
    it.value_b    = b;
    it.value_c    = c;
    return it;
  endfunction

  function automatic vhmm_pkg::in_t mk_obs(int cnt, bit last);
    vhmm_pkg::in_t it;
    it = rand_bits();
    it.req_type  = vhmm_pkg::REQ_OBS;
    it.obs_count = 8'(cnt);
    it.obs_last  = last;
    return it;
  endfunction

  // A plausible log value: mostly moderate negatives, sometimes anything.
  function automatic logic [31:0] rand_log();
    if ($urandom_range(9) == 0) return $urandom;
    return -32'($urandom_range(20 << 16));
  endfunction

  function automatic logic [31:0] rand_lrate();
    if ($urandom_range(9) == 0) return $urandom;
    return 32'($urandom_range(6 << 16)) - 32'(2 << 16);
  endfunction

  function automatic logic [30:0] rand_rate();
    if ($urandom_range(9) == 0) return 31'($urandom);
    return 31'($urandom_range(300 << 16));
  endfunction

  task automatic send_seq(int len);
    for (int t = 0; t < len; t++) send_item(mk_obs($urandom_range(255), t == len - 1));
  endtask

  // Fill every table entry, all zero or at random.
  task automatic test_load_tables(bit zeros);
    for (int f = 0; f < NST; f++) begin
      for (int t = 0; t < NST; t++) send_item(mk_trans(f, t, zeros ? 32'd0 : rand_log()));
      send_item(zeros ? mk_param(f, 32'd0, 32'd0, 31'd0)
                      : mk_param(f, rand_log(), rand_lrate(), rand_rate()));
    end
  endtask

  // All-zero tables: every comparison ties, so the lowest state must win.
  task automatic test_ties();
    test_load_tables(1'b1);
    send_item(mk_obs(0, 1'b1));
    send_seq(4);
  endtask

  // Field extremes, saturation both ways, count limits and the unused code.
  task automatic test_directed();
    vhmm_pkg::in_t it;
    send_item(mk_param(0, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF));
    send_item(mk_param(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0));
    send_item(mk_trans(0, 1, 32'h8000_0000));
    send_item(mk_trans(1, 0, 32'h7FFF_FFFF));
    send_item(mk_trans(7, 7, 32'h7FFF_FFFF));
    send_item(mk_obs(0, 1'b1));
    send_item(mk_obs(255, 1'b0));
    send_item(mk_obs(255, 1'b0));
    send_item(mk_obs(0, 1'b1));
    it = rand_bits();
    it.req_type = vhmm_pkg::REQ_UNUSED;
    send_item(it);
    send_item(mk_obs(1, 1'b0));
    // A load in the middle of a sequence takes effect at once.
    send_item(mk_param(1, 32'hFFFF_0000, 32'h0001_0000, 31'h0001_0000));
    send_item(mk_trans(0, 0, 32'h7FFF_FFFF));
    send_item(mk_obs(128, 1'b1));
    // Pause until the whole path has come out.
    drain();
  endtask

  // Sequence longer than the backpointer store, then a short clean one.
  task automatic test_overflow();
    send_seq(SEQ_MAX + 6);
    send_seq(4);
    drain();
  endtask

  // State count sweep, including values clamped at both ends.
  task automatic test_nstates();
    logic [3:0] sweep[6] = '{4'd0, 4'd1, 4'd15, 4'd8, 4'd5, 4'd2};
    foreach (sweep[i]) begin
      write_nstates(sweep[i]);
      send_seq(3);
      send_seq(1);
    end
  endtask

  // Random sequences with interleaved loads, noise and config changes.
  task automatic test_random();
    vhmm_pkg::in_t it;
    int            pick;
    int            len;
    while (item_cnt < 360) begin
      if (item_cnt > 280 && item_cnt < 330) calm = 1'b1;
      else calm = 1'b0;
      pick = $urandom_range(99);
      if (pick < 8) begin
        write_nstates(4'($urandom));
      end else if (pick < 18) begin
        it = rand_bits();
        if (it.req_type == vhmm_pkg::REQ_TRANS)
          it = mk_trans(int'(it.from_state), int'(it.to_state), rand_log());
        else if (it.req_type == vhmm_pkg::REQ_PARAM)
          it = mk_param(int'(it.from_state), rand_log(), rand_lrate(), rand_rate());
        else if (it.req_type == vhmm_pkg::REQ_OBS) it.obs_last = 1'b1;
        send_item(it);
      end else begin
        len = ($urandom_range(19) == 0) ? $urandom_range(70) : $urandom_range(1, 10);
        for (int t = 0; t <= len; t++) begin
          if ($urandom_range(9) == 0)
            send_item(mk_trans($urandom_range(7), $urandom_range(7), rand_log()));
          send_item(mk_obs($urandom_range(255), t == len));
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    start       = 1'b0;
    in_data     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    rst_n       = 1'b0;
    err_cnt     = 0;
    item_cnt    = 0;
    calm        = 1'b0;
    nstates_reg = 4'd2;
    seq_pos     = 0;
    seq_ovf     = 1'b0;
    for (int i = 0; i < NST; i++) begin
      score_prev[i] = 0;
      score_cur[i]  = 0;
    end
    build_lnfact();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_nstates(4'd8);
    test_ties();
    test_load_tables(1'b0);
    test_directed();
    test_overflow();
    test_nstates();
    test_random();

    drain();
    repeat (200) @(posedge clk);
    if (path_q.size() != 0) report("path entries never seen", 0, path_q.size());
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/vhmm_pkg.sv
design/vhmm_emission.sv
design/poisson_hmm_viterbi_decoder_top.sv
verif/tb_top.sv
